// ===== src/block_free_map_allocator_top_defines.svh =====
// Assertion helpers for the free map allocator. They use the local clk and rst_n.
`ifndef BLOCK_FREE_MAP_ALLOCATOR_TOP_DEFINES_SVH
`define BLOCK_FREE_MAP_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BFMA_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfma assertion failed");
`define BFMA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfma assertion failed");
`else
`define BFMA_ASSERT_SAME(name, ante, cons)
`define BFMA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== src/bfma_pkg.sv =====
`timescale 1ns / 1ps
package bfma_pkg;

  localparam int MAP_ENTRIES = 1024;
  localparam int MAX_REQUEST = 64;

  // map is held as WORDS rows of WORD_W marks; always at least two rows
  localparam int WORD_W  = (MAP_ENTRIES >= 64) ? 32 : MAP_ENTRIES / 2;
  localparam int WORDS   = MAP_ENTRIES / WORD_W;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WADDR_W = $clog2(WORDS);
  localparam int IDX_W   = BIT_W + WADDR_W;

  localparam int BLK_W = 16;
  localparam int OP_W  = 3;
  localparam int CNT_W = 7;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_FIND_ONE   = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND_COUNT = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK_FREE  = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK_ALLOC = 3'd3;
  localparam logic [OP_W-1:0] OP_FORMAT     = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SC_RD,
    S_SC_EVAL,
    S_MK_RD,
    S_MK_WR,
    S_END
  } state_t;

  typedef struct packed {
    logic            latch;
    logic            rd_first;
    logic            rd_next;
    logic            emit_found;
    logic            emit_end;
    logic [ST_W-1:0] end_status;
    logic            mk_read;
    logic            mk_write;
    logic            format;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            outside;
    logic            cur_nonzero;
    logic            last_word;
    logic            last_found;
    logic            out_free;
  } ctrl_sts_t;

endpackage

// ===== src/bfma_ctrl.sv =====
`timescale 1ns / 1ps
`include "block_free_map_allocator_top_defines.svh"
module bfma_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bfma_pkg::ctrl_sts_t  sts,
  output bfma_pkg::ctrl_cmd_t  cmd
);
  import bfma_pkg::*;

  state_t          state_r, state_nxt;
  logic [ST_W-1:0] end_st_r, end_st_nxt;
  logic            accept;

  assign accept = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      end_st_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      end_st_r <= end_st_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    end_st_nxt = end_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts.op) inside
          OP_FIND_ONE: state_nxt = S_SC_RD;
          OP_FIND_COUNT: begin
            if (sts.cnt_zero) begin
              end_st_nxt = ST_OK;
              state_nxt  = S_END;
            end else begin
              state_nxt = S_SC_RD;
            end
          end
          OP_MARK_FREE, OP_MARK_ALLOC: begin
            if (sts.outside) begin
              end_st_nxt = ST_OUTSIDE;
              state_nxt  = S_END;
            end else begin
              state_nxt = S_MK_RD;
            end
          end
          OP_FORMAT: begin
            end_st_nxt = ST_OK;
            state_nxt  = S_END;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SC_RD: state_nxt = S_SC_EVAL;
      S_SC_EVAL: begin
        if (sts.cur_nonzero) begin
          if (sts.out_free && sts.last_found) state_nxt = S_IDLE;
        end else if (sts.last_word) begin
          end_st_nxt = ST_NOSPACE;
          state_nxt  = S_END;
        end
      end
      S_MK_RD: state_nxt = S_MK_WR;
      S_MK_WR: begin
        end_st_nxt = ST_OK;
        state_nxt  = S_END;
      end
      S_END: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.end_status = end_st_r;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = accept;
      end
      S_DISPATCH: cmd.format = (sts.op == OP_FORMAT);
      S_SC_RD:    cmd.rd_first = 1'b1;
      S_SC_EVAL: begin
        if (sts.cur_nonzero) cmd.emit_found = sts.out_free;
        else                 cmd.rd_next = !sts.last_word;
      end
      S_MK_RD:    cmd.mk_read = 1'b1;
      S_MK_WR:    cmd.mk_write = 1'b1;
      S_END:      cmd.emit_end = sts.out_free;
      default: ;
    endcase
  end

  `BFMA_ASSERT_NEXT(a_accept_dispatch, accept, state_r == S_DISPATCH)
  `BFMA_ASSERT_SAME(a_found_has_room, cmd.emit_found, sts.out_free)
  `BFMA_ASSERT_SAME(a_end_has_room, cmd.emit_end, sts.out_free)
  `BFMA_ASSERT_NEXT(a_scan_exhausted,
    state_r == S_SC_EVAL && !sts.cur_nonzero && sts.last_word,
    state_r == S_END && end_st_r == ST_NOSPACE)

endmodule

// ===== src/bfma_dp.sv =====
`timescale 1ns / 1ps
module bfma_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [bfma_pkg::OP_W-1:0]           in_operation,
  input  logic [bfma_pkg::BLK_W-1:0]          in_block_number,
  input  logic [bfma_pkg::CNT_W-1:0]          in_count,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [bfma_pkg::BLK_W-1:0]          out_found_block,
  output logic [bfma_pkg::ST_W-1:0]           out_status,
  output logic                                out_last,
  input  logic                                cfg_wr_en,
  input  logic [bfma_pkg::BLK_W-1:0]          cfg_wr_data,
  input  bfma_pkg::ctrl_cmd_t                 cmd,
  output bfma_pkg::ctrl_sts_t                 sts
);
  import bfma_pkg::*;

  logic [WORD_W-1:0]  mem [WORDS];
  logic [WORD_W-1:0]  rd_data_r;
  logic               rd_valid_r;
  logic [WORDS-1:0]   row_valid_r;

  logic [OP_W-1:0]    op_r;
  logic [BLK_W-1:0]   bn_r;
  logic [CNT_W-1:0]   cnt_r, n_r;
  logic [BLK_W-1:0]   base_r;
  logic [WADDR_W-1:0] word_addr_r;
  logic [WORD_W-1:0]  word_r;
  logic               fresh_r;

  logic               out_valid_r;
  logic [BLK_W-1:0]   found_r;
  logic [ST_W-1:0]    status_r;
  logic               last_r;

  logic [BLK_W:0]     diff;
  logic [IDX_W-1:0]   mk_idx;
  logic [WADDR_W-1:0] mk_word;
  logic [BIT_W-1:0]   mk_bit;
  logic [WORD_W-1:0]  mem_word, cur, wr_data;
  logic [WADDR_W-1:0] rd_addr;
  logic               mem_re;
  logic [BIT_W-1:0]   pos;
  logic [CNT_W-1:0]   cnt_sat;

  // a row that is not valid has not been written since reset or format: all free
  assign mem_word = rd_valid_r ? rd_data_r : '1;
  assign cur      = fresh_r ? mem_word : word_r;

  assign diff    = {1'b0, bn_r} - {1'b0, base_r};
  assign mk_idx  = diff[IDX_W-1:0];
  assign mk_word = mk_idx[IDX_W-1:BIT_W];
  assign mk_bit  = mk_idx[BIT_W-1:0];

  assign cnt_sat = (in_count > CNT_W'(MAX_REQUEST)) ? CNT_W'(MAX_REQUEST) : in_count;

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cur[i]) pos = BIT_W'(i);
    end
  end

  always_comb begin
    wr_data         = mem_word;
    wr_data[mk_bit] = (op_r == OP_MARK_FREE);
  end

  always_comb begin
    rd_addr = '0;
    if (cmd.rd_next)      rd_addr = word_addr_r + WADDR_W'(1);
    else if (cmd.mk_read) rd_addr = mk_word;
  end
  assign mem_re = cmd.rd_first || cmd.rd_next || cmd.mk_read;

  always_ff @(posedge clk) begin
    if (cmd.mk_write) mem[mk_word] <= wr_data;
    if (mem_re) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= row_valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      base_r      <= '0;
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) base_r <= cfg_wr_data;
      if (cmd.format)        row_valid_r <= '0;
      else if (cmd.mk_write) row_valid_r[mk_word] <= 1'b1;
      if (cmd.rd_first || cmd.rd_next) fresh_r <= 1'b1;
      else if (cmd.emit_found)         fresh_r <= 1'b0;
      if (cmd.emit_found || cmd.emit_end) out_valid_r <= 1'b1;
      else if (out_ready)                 out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_operation;
      bn_r  <= in_block_number;
      cnt_r <= cnt_sat;
      n_r   <= '0;
    end else if (cmd.emit_found) begin
      n_r <= n_r + CNT_W'(1);
    end
    if (cmd.rd_first)     word_addr_r <= '0;
    else if (cmd.rd_next) word_addr_r <= rd_addr;
    if (cmd.emit_found) begin
      word_r   <= cur & (cur - WORD_W'(1));
      found_r  <= base_r + BLK_W'({word_addr_r, pos});
      status_r <= ST_OK;
      last_r   <= sts.last_found;
    end else if (cmd.emit_end) begin
      found_r  <= '0;
      status_r <= cmd.end_status;
      last_r   <= 1'b1;
    end
  end

  always_comb begin
    sts             = '0;
    sts.op          = op_r;
    sts.cnt_zero    = (cnt_r == '0);
    sts.outside     = diff[BLK_W] || (diff >= (BLK_W + 1)'(MAP_ENTRIES));
    sts.cur_nonzero = (cur != '0);
    sts.last_word   = (word_addr_r == WADDR_W'(WORDS - 1));
    sts.last_found  = (op_r == OP_FIND_ONE) || ((n_r + CNT_W'(1)) == cnt_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_found_block = found_r;
  assign out_status      = status_r;
  assign out_last        = last_r;

endmodule

// ===== src/block_free_map_allocator_top.sv =====
`timescale 1ns / 1ps
// channel  | ports                                                 | handshake
// in       | in_operation, in_block_number, in_count               | in_valid / in_ready
// out      | out_found_block, out_status, out_last                 | out_valid / out_ready
// cfg      | cfg_wr_data (data_base)                               | cfg_wr_en, no wait
//
// One request at a time. Find reads the map one 32-mark row at a time from the first row,
// through the single read port of the map memory, and gives one result per free mark
// found, up to the requested count. Mark is a read-modify-write of one row, skipped
// when the block is outside the map. Format clears the map.
// Reset and format clear only the per-row valid flops; no clearing pass is needed.
// A stalled result holds the scan in place; the next request is taken once the
// final result is in the output register.
module block_free_map_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bfma_pkg::OP_W-1:0]           in_operation,
  input  logic [bfma_pkg::BLK_W-1:0]          in_block_number,
  input  logic [bfma_pkg::CNT_W-1:0]          in_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bfma_pkg::BLK_W-1:0]          out_found_block,
  output logic [bfma_pkg::ST_W-1:0]           out_status,
  output logic                                out_last,
  input  logic                                cfg_wr_en,
  input  logic [bfma_pkg::BLK_W-1:0]          cfg_wr_data
);
  import bfma_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bfma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfma_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_block_number (in_block_number),
    .in_count        (in_count),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_found_block (out_found_block),
    .out_status      (out_status),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ===== tb/block_free_map_allocator_top_test.sv =====
`timescale 1ns / 1ps
module block_free_map_allocator_top_test;
  import bfma_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;
  localparam int RANDOM_ITEMS  = 170;
  localparam int TAIL_ITEMS    = 30;
  localparam int DRAIN_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_MAX    = 10;
  localparam int N_ROWS        = 26;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [ST_W-1:0]  st;
    logic             last;
  } alloc_result_t;

  typedef enum { R_ITEM, R_BASE } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] bn;
    logic [CNT_W-1:0] cnt;
    int               reps;
    bit               typed;
    logic [BLK_W-1:0] exp_blk;
    logic [ST_W-1:0]  exp_st;
  } stim_row_t;

  // typed rows carry the single result of the request; the rest use the predictor
  stim_row_t directed_rows [N_ROWS] = '{
    '{R_BASE, OP_FIND_ONE,    16'd0,     7'd0,   1,    1'b0, 16'd0,   ST_OK},
    '{R_ITEM, OP_FIND_ONE,    16'd0,     7'd0,   1,    1'b1, 16'd0,   ST_OK},
    '{R_ITEM, OP_FIND_COUNT,  16'd0,     7'd0,   1,    1'b1, 16'd0,   ST_OK},
    '{R_ITEM, OP_FIND_COUNT,  16'd0,     7'd3,   1,    1'b0, 16'd0,   ST_OK},
    '{R_ITEM, OP_MARK_ALLOC,  16'd0,     7'd0,   1,    1'b1, 16'd0,   ST_OK},
    '{R_ITEM, OP_MARK_ALLOC,  16'd1023,  7'd0,   1,    1'b1, 16'd0,   ST_OK},
    '{R_ITEM, OP_MARK_ALLOC,  16'd1024,  7'd0,   1,    1'b1, 16'd0,   ST_OUTSIDE},
    '{R_ITEM, OP_MARK_FREE,   16'hFFFF,  7'd0,   1,    1'b1, 16'd0,   ST_OUTSIDE},
    '{R_ITEM, OP_FIND_ONE,    16'hFFFF,  7'h7F,  1,    1'b0, 16'd0,   ST_OK},
    '{R_ITEM, OP_FIND_COUNT,  16'd0,     7'd127, 1,    1'b0, 16'd0,   ST_OK},
    '{R_ITEM, OP_RESERVED_LO, 16'd0,     7'd0,   1,    1'b0, 16'd0,   ST_OK},
    '{R_ITEM, OP_RESERVED_HI, 16'hFFFF,  7'h7F,  1,    1'b0, 16'd0,   ST_OK},
    '{R_BASE, OP_FIND_ONE,    16'hFFFF,  7'd0,   1,    1'b0, 16'd0,   ST_OK},
    '{R_ITEM, OP_FIND_ONE,    16'd0,     7'd0,   1,    1'b0, 16'd0,   ST_OK},
    '{R_ITEM, OP_MARK_ALLOC,  16'hFFFE,  7'd0,   1,    1'b1, 16'd0,   ST_OUTSIDE},
    '{R_ITEM, OP_MARK_FREE,   16'hFFFF,  7'd0,   1,    1'b1, 16'd0,   ST_OK},
    '{R_BASE, OP_FIND_ONE,    16'd100,   7'd0,   1,    1'b0, 16'd0,   ST_OK},
    // fill the whole map so the searches run dry
    '{R_ITEM, OP_MARK_ALLOC,  16'd100,   7'd0,   1024, 1'b1, 16'd0,   ST_OK},
    '{R_ITEM, OP_FIND_ONE,    16'd0,     7'd0,   1,    1'b1, 16'd0,   ST_NOSPACE},
    '{R_ITEM, OP_FIND_COUNT,  16'd0,     7'd64,  1,    1'b1, 16'd0,   ST_NOSPACE},
    '{R_ITEM, OP_MARK_FREE,   16'd1123,  7'd0,   1,    1'b1, 16'd0,   ST_OK},
    '{R_ITEM, OP_MARK_FREE,   16'd600,   7'd0,   1,    1'b1, 16'd0,   ST_OK},
    '{R_ITEM, OP_FIND_COUNT,  16'd0,     7'd5,   1,    1'b0, 16'd0,   ST_OK},
    '{R_ITEM, OP_FIND_COUNT,  16'd0,     7'd1,   1,    1'b0, 16'd0,   ST_OK},
    '{R_ITEM, OP_FORMAT,      16'd0,     7'd0,   1,    1'b1, 16'd0,   ST_OK},
    '{R_ITEM, OP_FIND_ONE,    16'd0,     7'd0,   1,    1'b1, 16'd100, ST_OK}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_operation;
  logic [BLK_W-1:0] in_block_number;
  logic [CNT_W-1:0] in_count;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [BLK_W-1:0] out_found_block;
  logic [ST_W-1:0]  out_status;
  logic             out_last;
  logic             cfg_wr_en;
  logic [BLK_W-1:0] cfg_wr_data;

  bit               free_marks [MAP_ENTRIES];
  logic [BLK_W-1:0] base_reg;
  alloc_result_t    step_results [$];
  alloc_result_t    pending_results [$];
  alloc_result_t    want_res;
  alloc_result_t    got_res;
  int               mismatches = 0;
  int               stall_left = 0;
  int               cycle_count = 0;
  bit               steady_tail;

  block_free_map_allocator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_block_number (in_block_number),
    .in_count        (in_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found_block (out_found_block),
    .out_status      (out_status),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int first_free_index();
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      if (free_marks[i]) return i;
    end
    return -1;
  endfunction

  // first-fit search and mark bookkeeping; fills step_results for one request
  function automatic void serve_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] bn,
                                        logic [CNT_W-1:0] cnt);
    int want;
    int n;
    int off;
    int idx;
    step_results.delete();
    case (op) inside
      OP_FIND_ONE: begin
        idx = first_free_index();
        if (idx >= 0) step_results.push_back('{BLK_W'(base_reg + idx), ST_OK, 1'b1});
        else step_results.push_back('{'0, ST_NOSPACE, 1'b1});
      end
      OP_FIND_COUNT: begin
        want = (cnt > MAX_REQUEST) ? MAX_REQUEST : int'(cnt);
        n = 0;
        if (want == 0) begin
          step_results.push_back('{'0, ST_OK, 1'b1});
        end else begin
          for (int i = 0; i < MAP_ENTRIES && n < want; i++) begin
            if (free_marks[i]) begin
              n++;
              step_results.push_back('{BLK_W'(base_reg + i), ST_OK, n == want});
            end
          end
          if (n < want) step_results.push_back('{'0, ST_NOSPACE, 1'b1});
        end
      end
      OP_MARK_FREE, OP_MARK_ALLOC: begin
        off = int'(bn) - int'(base_reg);
        if (off < 0 || off >= MAP_ENTRIES) begin
          step_results.push_back('{'0, ST_OUTSIDE, 1'b1});
        end else begin
          free_marks[off] = (op == OP_MARK_FREE);
          step_results.push_back('{'0, ST_OK, 1'b1});
        end
      end
      OP_FORMAT: begin
        foreach (free_marks[i]) free_marks[i] = 1'b1;
        step_results.push_back('{'0, ST_OK, 1'b1});
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] bn,
                              logic [CNT_W-1:0] cnt, bit typed,
                              logic [BLK_W-1:0] exp_blk, logic [ST_W-1:0] exp_st);
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_block_number <= bn;
    in_count        <= cnt;
    do @(posedge clk); while (!in_ready);
    serve_request(op, bn, cnt);
    if (typed) pending_results.push_back('{exp_blk, exp_st, 1'b1});
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  // block must be idle before the base register moves
  task automatic set_base(logic [BLK_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_reg = value;
  endtask

  task automatic report(string what);
    if (mismatches < REPORT_MAX)
      $display("%s: expected blk %0d st %0d last %0d, got blk %0d st %0d last %0d", what,
               want_res.blk, want_res.st, want_res.last, got_res.blk, got_res.st,
               got_res.last);
    mismatches++;
  endtask

  // result side: check each transfer, then pick out_ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_res = '{out_found_block, out_status, out_last};
      if (pending_results.size() == 0) begin
        want_res = '0;
        report("unexpected result");
      end else begin
        want_res = pending_results.pop_front();
        if (got_res !== want_res) report("result mismatch");
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int counted;
    int choice;
    int idx;
    logic [BLK_W-1:0] phase_base;
    logic [CNT_W-1:0] cnt;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_FIND_ONE;
    in_block_number = '0;
    in_count        = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    steady_tail     = 1'b0;
    counted         = 0;
    base_reg        = '0;
    foreach (free_marks[i]) free_marks[i] = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == R_BASE) begin
        set_base(directed_rows[r].bn);
      end else begin
        for (int k = 0; k < directed_rows[r].reps; k++)
          send_request(directed_rows[r].op, BLK_W'(directed_rows[r].bn + k),
                       directed_rows[r].cnt, directed_rows[r].typed,
                       directed_rows[r].exp_blk, directed_rows[r].exp_st);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: phase_base = BLK_W'(65536 - MAP_ENTRIES);
        2: phase_base = '0;
        default: phase_base = BLK_W'($urandom);
      endcase
      set_base(phase_base);
      while (counted < (phase + 1) * RANDOM_ITEMS / 4) begin
        steady_tail = (counted >= RANDOM_ITEMS - TAIL_ITEMS);
        choice = $urandom_range(0, 99);
        if (choice < 30) begin
          // claim: find the first free block, then mark it allocated
          idx = first_free_index();
          send_request(OP_FIND_ONE, BLK_W'($urandom), CNT_W'($urandom), 1'b0, '0, ST_OK);
          counted++;
          if (idx >= 0) begin
            send_request(OP_MARK_ALLOC, BLK_W'(base_reg + idx), CNT_W'($urandom), 1'b0,
                         '0, ST_OK);
            counted++;
          end
        end else if (choice < 45) begin
          case ($urandom_range(0, 9))
            0: cnt = '0;
            1: cnt = CNT_W'($urandom_range(MAX_REQUEST + 1, 127));
            2: cnt = CNT_W'($urandom_range(9, MAX_REQUEST));
            default: cnt = CNT_W'($urandom_range(1, 8));
          endcase
          send_request(OP_FIND_COUNT, BLK_W'($urandom), cnt, 1'b0, '0, ST_OK);
          counted++;
        end else if (choice < 65) begin
          // release an allocated block if one exists, else free a random block
          idx = $urandom_range(0, MAP_ENTRIES - 1);
          for (int j = 0; j < MAP_ENTRIES; j++) begin
            if (!free_marks[(idx + j) % MAP_ENTRIES]) begin
              idx = (idx + j) % MAP_ENTRIES;
              break;
            end
          end
          send_request(OP_MARK_FREE, BLK_W'(base_reg + idx), CNT_W'($urandom), 1'b0,
                       '0, ST_OK);
          counted++;
        end else if (choice < 78) begin
          send_request(OP_MARK_ALLOC, BLK_W'(base_reg + $urandom_range(0, MAP_ENTRIES - 1)),
                       CNT_W'($urandom), 1'b0, '0, ST_OK);
          counted++;
        end else if (choice < 92) begin
          send_request(OP_W'($urandom_range(OP_MARK_ALLOC, OP_MARK_FREE)), BLK_W'($urandom),
                       CNT_W'($urandom), 1'b0, '0, ST_OK);
          counted++;
        end else if (choice < 95) begin
          send_request(OP_FORMAT, BLK_W'($urandom), CNT_W'($urandom), 1'b0, '0, ST_OK);
          counted++;
        end else begin
          send_request(OP_W'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO)),
                       BLK_W'($urandom), CNT_W'($urandom), 1'b0, '0, ST_OK);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
